/* src/sst_pkg.sv */
`default_nettype none
package sst_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int RANDOM_BITS_DEF = 16;

  localparam int LEVEL_BITS = 8;
  localparam int TICK_BITS  = 20;
  localparam int FLASH_BITS = 20;
  localparam int HALF_BITS  = 19;
  localparam int ADD_BITS   = 22;
  localparam int NUM_BITS   = 26;
  localparam int DEN_BITS   = 11;

  localparam logic [LEVEL_BITS-1:0] LVL_STROBE_MIN = 8'd16;
  localparam logic [LEVEL_BITS-1:0] LVL_RANDOM_MIN = 8'd129;
  localparam logic [LEVEL_BITS-1:0] LVL_OPEN_MIN   = 8'd240;

  localparam logic [DEN_BITS-1:0] PER_BASE = 11'd112;
  localparam logic [DEN_BITS-1:0] RND_BASE = 11'd110;

  localparam logic [NUM_BITS-1:0] PER_NUM = 26'd56000000;
  localparam logic [NUM_BITS-1:0] RND_NUM = 26'd55000000;

  localparam logic [FLASH_BITS-1:0] FLASH_RESET = 20'd50000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DECIDE,
    ST_MUL,
    ST_UPD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    TOP_TICK,
    TOP_UPD_NT,
    TOP_UPD_RT
  } time_op_t;

  typedef struct packed {
    logic     start;
    time_op_t op;
  } time_ctl_t;

  typedef struct packed {
    logic busy;
    logic le;
  } time_sts_t;

endpackage
`default_nettype wire

/* src/sst_time.sv */
`default_nettype none
module sst_time #(
  parameter int TIME_BITS = sst_pkg::TIME_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire sst_pkg::time_ctl_t         time_ctl,
  input  wire [sst_pkg::TICK_BITS-1:0]    tick,
  input  wire [sst_pkg::ADD_BITS-1:0]     addend,
  output sst_pkg::time_sts_t              time_sts
);

  localparam int CW = $clog2(TIME_BITS);

  logic [TIME_BITS-1:0]          rt_r, rt_nxt;
  logic [TIME_BITS-1:0]          nt_r, nt_nxt;
  logic [sst_pkg::TICK_BITS-1:0] tick_r, tick_nxt;
  logic [sst_pkg::ADD_BITS-1:0]  add_r, add_nxt;
  logic                          carry_r, carry_nxt;
  logic                          le_r, le_nxt;
  logic                          busy_r, busy_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  sst_pkg::time_op_t             op_r, op_nxt;

  logic a_bit;
  logic b_bit;
  logic sum_bit;
  logic carry_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r    <= '0;
      nt_r    <= '0;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      op_r    <= sst_pkg::TOP_TICK;
      carry_r <= 1'b0;
      le_r    <= 1'b1;
    end else begin
      rt_r    <= rt_nxt;
      nt_r    <= nt_nxt;
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      carry_r <= carry_nxt;
      le_r    <= le_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r <= tick_nxt;
    add_r  <= add_nxt;
  end

  always_comb begin
    unique case (op_r)
      sst_pkg::TOP_TICK: begin
        a_bit = rt_r[0];
        b_bit = tick_r[0];
      end
      sst_pkg::TOP_UPD_NT: begin
        a_bit = nt_r[0];
        b_bit = add_r[0];
      end
      sst_pkg::TOP_UPD_RT: begin
        a_bit = rt_r[0];
        b_bit = add_r[0];
      end
      default: begin
        a_bit = 1'b0;
        b_bit = 1'b0;
      end
    endcase
    sum_bit = a_bit ^ b_bit ^ carry_r;
    carry_c = (a_bit & b_bit) | (a_bit & carry_r) | (b_bit & carry_r);
  end

  always_comb begin
    rt_nxt    = rt_r;
    nt_nxt    = nt_r;
    tick_nxt  = tick_r;
    add_nxt   = add_r;
    carry_nxt = carry_r;
    le_nxt    = le_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    if (time_ctl.start) begin
      tick_nxt  = tick;
      add_nxt   = addend;
      carry_nxt = 1'b0;
      le_nxt    = 1'b1;
      busy_nxt  = 1'b1;
      cnt_nxt   = CW'(TIME_BITS - 1);
      op_nxt    = time_ctl.op;
    end else if (busy_r) begin
      carry_nxt = carry_c;
      tick_nxt  = tick_r >> 1;
      add_nxt   = add_r >> 1;
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
      if (op_r == sst_pkg::TOP_TICK) begin
        rt_nxt = {sum_bit, rt_r[TIME_BITS-1:1]};
        nt_nxt = {nt_r[0], nt_r[TIME_BITS-1:1]};
        le_nxt = (~nt_r[0] & sum_bit) | (~(nt_r[0] ^ sum_bit) & le_r);
      end else begin
        rt_nxt = {rt_r[0], rt_r[TIME_BITS-1:1]};
        nt_nxt = {sum_bit, nt_r[TIME_BITS-1:1]};
      end
    end
  end

  assign time_sts.busy = busy_r;
  assign time_sts.le   = le_r;

endmodule
`default_nettype wire

/* src/sst_div.sv */
`default_nettype none
module sst_div (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire [sst_pkg::LEVEL_BITS-1:0]  level,
  output logic                           busy,
  output logic [sst_pkg::HALF_BITS-1:0]  half
);

  localparam int NB = sst_pkg::NUM_BITS;
  localparam int DB = sst_pkg::DEN_BITS;
  localparam int CW = $clog2(NB);

  logic [NB-1:0] q_r, q_nxt;
  logic [DB-1:0] rem_r, rem_nxt;
  logic [DB-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic                          rnd_mode;
  logic [sst_pkg::LEVEL_BITS-1:0] offset;
  logic [6:0]                    off7;
  logic [DB-1:0]                 den_c;
  logic [DB:0]                   trial;
  logic [DB:0]                   diff;
  logic                          ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  always_comb begin
    rnd_mode = level >= sst_pkg::LVL_RANDOM_MIN;
    offset   = level - (rnd_mode ? sst_pkg::LVL_RANDOM_MIN : sst_pkg::LVL_STROBE_MIN);
    off7     = offset[6:0];
    den_c    = DB'({off7, 3'b000}) + DB'(off7)
             + (rnd_mode ? sst_pkg::RND_BASE : sst_pkg::PER_BASE);
    trial    = {rem_r, q_r[NB-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = rnd_mode ? sst_pkg::RND_NUM : sst_pkg::PER_NUM;
      rem_nxt  = '0;
      den_nxt  = den_c;
      cnt_nxt  = CW'(NB - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[NB-2:0], ge};
      rem_nxt = ge ? diff[DB-1:0] : trial[DB-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign half = q_r[sst_pkg::HALF_BITS-1:0];

endmodule
`default_nettype wire

/* src/sst_mul.sv */
`default_nettype none
module sst_mul #(
  parameter int RANDOM_BITS = sst_pkg::RANDOM_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire [sst_pkg::HALF_BITS-1:0]   half,
  input  wire [RANDOM_BITS-1:0]          rnd,
  output logic                           busy,
  output logic [sst_pkg::ADD_BITS-1:0]   gap
);

  localparam int AB = sst_pkg::ADD_BITS;
  localparam int CW = $clog2(RANDOM_BITS);

  logic [AB-1:0]                 acc_r, acc_nxt;
  logic [AB-1:0]                 m5_r, m5_nxt;
  logic [sst_pkg::HALF_BITS-1:0] hp_r, hp_nxt;
  logic [RANDOM_BITS-1:0]        mq_r, mq_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;

  logic [AB:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    m5_r  <= m5_nxt;
    hp_r  <= hp_nxt;
    mq_r  <= mq_nxt;
  end

  assign sum = {1'b0, acc_r} + {1'b0, (mq_r[0] ? m5_r : '0)};

  always_comb begin
    acc_nxt  = acc_r;
    m5_nxt   = m5_r;
    hp_nxt   = hp_r;
    mq_nxt   = mq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      m5_nxt   = AB'({half, 2'b00}) + AB'(half);
      hp_nxt   = half;
      mq_nxt   = rnd;
      cnt_nxt  = CW'(RANDOM_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[AB:1];
      mq_nxt  = {sum[0], mq_r[RANDOM_BITS-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign gap  = acc_r + AB'(hp_r);

endmodule
`default_nettype wire

/* src/strobe_shutter_timer_unit.sv */
`default_nettype none
// Strobe shutter timer. A level write (in_command = 1) is taken without leaving idle and
// gives no result. A tick (in_command = 0) gives one shutter_open result and
// keeps in_stall high through a pass over the running clock, a second pass when
// a deadline is rescheduled (after the gap multiplication when a random-flash
// gap is scaled). The running clock and the next deadline are held as TIME_BITS
// shift registers and go through a one-bit serial adder and comparator, one full
// pass per tick plus one per rescheduling; the half period comes from a 26-step
// restoring divider that overlaps the first pass, and the gap scaling from a
// RANDOM_BITS-step shift-add multiplier. A finished result waits in the output
// register while the next transaction is taken.
module strobe_shutter_timer_unit #(
  parameter int TIME_BITS   = sst_pkg::TIME_BITS_DEF,
  parameter int RANDOM_BITS = sst_pkg::RANDOM_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_command,
  input  wire [sst_pkg::LEVEL_BITS-1:0]   in_strobe_level,
  input  wire [sst_pkg::TICK_BITS-1:0]    in_tick_us,
  input  wire [RANDOM_BITS-1:0]           in_random_value,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_shutter_open,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [sst_pkg::FLASH_BITS-1:0]   cfg_flash_open_us
);

  localparam int AB = sst_pkg::ADD_BITS;

  sst_pkg::state_t               state_r, state_nxt;
  logic [sst_pkg::LEVEL_BITS-1:0] level_r, level_nxt;
  logic                          changed_r, changed_nxt;
  logic                          armed_r, armed_nxt;
  logic                          shut_r, shut_nxt;
  logic [sst_pkg::FLASH_BITS-1:0] flash_r;
  logic [RANDOM_BITS-1:0]        rnd_r, rnd_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_shut_r, out_shut_nxt;

  sst_pkg::time_ctl_t            time_ctl;
  sst_pkg::time_sts_t            time_sts;
  logic [AB-1:0]                 addend;
  logic                          div_start;
  logic                          div_busy;
  logic [sst_pkg::HALF_BITS-1:0] half;
  logic                          mul_start;
  logic                          mul_busy;
  logic [AB-1:0]                 gap;
  logic                          in_accept;

  sst_time #(
    .TIME_BITS (TIME_BITS)
  ) u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .time_ctl (time_ctl),
    .tick     (in_tick_us),
    .addend   (addend),
    .time_sts (time_sts)
  );

  sst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .level (level_r),
    .busy  (div_busy),
    .half  (half)
  );

  sst_mul #(
    .RANDOM_BITS (RANDOM_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .half  (half),
    .rnd   (rnd_r),
    .busy  (mul_busy),
    .gap   (gap)
  );

  assign in_stall         = (state_r != sst_pkg::ST_IDLE);
  assign in_accept        = in_valid & ~in_stall;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_shutter_open = out_shut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sst_pkg::ST_IDLE;
      level_r     <= '0;
      changed_r   <= 1'b0;
      armed_r     <= 1'b0;
      shut_r      <= 1'b0;
      flash_r     <= sst_pkg::FLASH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      changed_r   <= changed_nxt;
      armed_r     <= armed_nxt;
      shut_r      <= shut_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        flash_r <= cfg_flash_open_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    out_shut_r <= out_shut_nxt;
  end

  always_comb begin
    logic l_closed;
    logic l_open;
    logic rnd_mode;
    logic upd;
    logic use_rt;
    logic use_flash;
    logic use_gap;

    l_closed  = level_r < sst_pkg::LVL_STROBE_MIN;
    l_open    = level_r >= sst_pkg::LVL_OPEN_MIN;
    rnd_mode  = level_r >= sst_pkg::LVL_RANDOM_MIN;
    upd       = 1'b0;
    use_rt    = 1'b0;
    use_flash = 1'b0;
    use_gap   = 1'b0;

    state_nxt     = state_r;
    level_nxt     = level_r;
    changed_nxt   = changed_r;
    armed_nxt     = armed_r;
    shut_nxt      = shut_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r;
    out_shut_nxt  = out_shut_r;
    time_ctl.start = 1'b0;
    time_ctl.op    = sst_pkg::TOP_TICK;
    addend        = '0;
    div_start     = 1'b0;
    mul_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sst_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_command) begin
            level_nxt   = in_strobe_level;
            changed_nxt = 1'b1;
          end else begin
            rnd_nxt        = in_random_value;
            time_ctl.start = 1'b1;
            time_ctl.op    = sst_pkg::TOP_TICK;
            div_start      = 1'b1;
            state_nxt      = sst_pkg::ST_TICK;
          end
        end
      end
      sst_pkg::ST_TICK: begin
        if (!time_sts.busy && !div_busy) begin
          state_nxt = sst_pkg::ST_DECIDE;
        end
      end
      sst_pkg::ST_DECIDE: begin
        changed_nxt = 1'b0;
        state_nxt   = sst_pkg::ST_EMIT;
        priority if (l_closed) begin
          shut_nxt  = 1'b0;
          armed_nxt = 1'b0;
        end else if (l_open) begin
          shut_nxt  = 1'b1;
          armed_nxt = 1'b0;
        end else begin
          if (armed_r) begin
            if (time_sts.le) begin
              shut_nxt = ~shut_r;
              upd      = 1'b1;
              if (rnd_mode && !shut_r) begin
                use_rt    = 1'b1;
                use_flash = 1'b1;
              end else if (rnd_mode) begin
                use_gap = 1'b1;
              end
            end
          end else begin
            shut_nxt  = 1'b0;
            armed_nxt = 1'b1;
            upd       = 1'b1;
            use_rt    = 1'b1;
          end
          if (changed_r) begin
            upd       = 1'b1;
            use_rt    = 1'b1;
            use_flash = 1'b0;
            use_gap   = 1'b0;
          end
        end
        if (upd) begin
          if (use_gap) begin
            mul_start = 1'b1;
            state_nxt = sst_pkg::ST_MUL;
          end else begin
            time_ctl.start = 1'b1;
            time_ctl.op    = use_rt ? sst_pkg::TOP_UPD_RT : sst_pkg::TOP_UPD_NT;
            addend         = use_flash ? AB'(flash_r) : AB'(half);
            state_nxt      = sst_pkg::ST_UPD;
          end
        end
      end
      sst_pkg::ST_MUL: begin
        if (!mul_busy) begin
          time_ctl.start = 1'b1;
          time_ctl.op    = sst_pkg::TOP_UPD_NT;
          addend         = gap;
          state_nxt      = sst_pkg::ST_UPD;
        end
      end
      sst_pkg::ST_UPD: begin
        if (!time_sts.busy) begin
          state_nxt = sst_pkg::ST_EMIT;
        end
      end
      sst_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_shut_nxt  = shut_r;
          state_nxt     = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/sst_checker.sv */
`default_nettype none
module sst_checker #(
  parameter int RANDOM_BITS = sst_pkg::RANDOM_BITS_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             in_command,
  input wire [sst_pkg::LEVEL_BITS-1:0]   in_strobe_level,
  input wire [sst_pkg::TICK_BITS-1:0]    in_tick_us,
  input wire [RANDOM_BITS-1:0]           in_random_value,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire                             out_shutter_open
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_shutter_open))
    else $error("stalled result changed");

  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable({in_command, in_strobe_level, in_tick_us, in_random_value}))
    else $error("stalled input transaction changed");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_command |=> in_stall)
    else $error("tick transaction did not occupy the timer");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command |=> !in_stall && !$rose(out_valid))
    else $error("level write stalled input or produced a result");

endmodule

bind strobe_shutter_timer_unit sst_checker #(
  .RANDOM_BITS (RANDOM_BITS)
) u_sst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_command        (in_command),
  .in_strobe_level   (in_strobe_level),
  .in_tick_us        (in_tick_us),
  .in_random_value   (in_random_value),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_shutter_open  (out_shutter_open)
);
`default_nettype wire
